// ===== sv/pvtb_pkg.sv =====
// ----------------------------------------------------------------------------
// pvtb_pkg
// Shared constants and types for the periodic virtual timer bank.
// ----------------------------------------------------------------------------
package pvtb_pkg;

  localparam int NUM_TIMERS  = 5;
  localparam int REG_COUNT   = 5;
  localparam int TIMER_W     = 32;
  localparam int REQ_W       = 2;
  localparam int TIMER_IDX_W = 3;
  localparam int REG_IDX_W   = 3;
  localparam int MASK_W      = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_CANCEL = 2'd2
  } req_kind_t;

  typedef logic [TIMER_W-1:0] tick_t;
  typedef logic [MASK_W-1:0]  mask_t;

endpackage

// ===== sv/pvtb_if.sv =====
// ----------------------------------------------------------------------------
// pvtb_if
// Valid/ready channels of the timer bank: requests, results, register writes.
// ----------------------------------------------------------------------------
interface pvtb_req_if import pvtb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [TIMER_IDX_W-1:0] timer_sel;

  modport source (output valid, output req_type, output timer_sel, input ready);
  modport sink   (input valid, input req_type, input timer_sel, output ready);
endinterface

interface pvtb_rsp_if import pvtb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [MASK_W-1:0] expired_mask;

  modport source (output valid, output expired_mask, input ready);
  modport sink   (input valid, input expired_mask, output ready);
endinterface

interface pvtb_cfg_if import pvtb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [TIMER_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/periodic_virtual_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_virtual_timer_bank
// Five periodic timers on a shared wrapping 32-bit tick counter.
// ----------------------------------------------------------------------------
// result: registered from the request transaction, into the skid entry while the output stalls
// throughput: 1 request per cycle while the skid entry is empty, set by the five parallel subtract-compare units
// results sit in an output register backed by one skid entry
// reset: tick counter, active flags, timeouts and result valids clear
// last firing ticks are not reset; they are written by a start before use
module periodic_virtual_timer_bank import pvtb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pvtb_req_if.sink   req,
  pvtb_rsp_if.source rsp,
  pvtb_cfg_if.sink   cfg
);

  tick_t                 tick_count;
  tick_t                 tick_next;
  tick_t                 timeout   [REG_COUNT];
  tick_t                 last_fire [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] fire;
  logic                  push;
  logic                  is_tick;
  logic                  idx_ok;
  mask_t                 new_mask;
  logic                  out_valid;
  mask_t                 out_mask;
  logic                  skid_valid;
  mask_t                 skid_mask;

  assign req.ready = !skid_valid;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.expired_mask = out_mask;

  assign push      = req.valid && req.ready;
  assign is_tick   = req.req_type == REQ_TICK;
  assign idx_ok    = req.timer_sel < TIMER_IDX_W'(NUM_TIMERS);
  assign tick_next = tick_count + tick_t'(1);

  // parallel period checks against the incremented count
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      fire[i] = is_tick && active[i] && ((tick_next - last_fire[i]) >= timeout[i]);
    end
    new_mask = mask_t'(fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      active     <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        timeout[i] <= '0;
      end
    end else begin
      if (push) begin
        case (req.req_type)
          REQ_TICK: begin
            tick_count <= tick_next;
          end
          REQ_START: begin
            if (idx_ok) begin
              active[req.timer_sel] <= 1'b1;
            end
          end
          REQ_CANCEL: begin
            if (idx_ok) begin
              active[req.timer_sel] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cfg.valid && cfg.ready && (cfg.index < REG_IDX_W'(REG_COUNT))) begin
        timeout[cfg.index] <= cfg.data;
        if (cfg.index < REG_IDX_W'(NUM_TIMERS)) begin
          active[cfg.index] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (fire[i]) begin
          last_fire[i] <= tick_next;
        end
      end
      if ((req.req_type == REQ_START) && idx_ok) begin
        last_fire[req.timer_sel] <= tick_count;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_mask <= skid_mask;
      end else if (push) begin
        out_mask <= new_mask;
      end
    end else if (push) begin
      skid_mask <= new_mask;
    end
  end

endmodule

// ===== sv/pvtb_checker.sv =====
// ----------------------------------------------------------------------------
// pvtb_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module pvtb_checker import pvtb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [MASK_W-1:0] rsp_mask
);

  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more requests in flight than result storage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd0 |-> req_ready)
    else $error("request stalled with nothing in flight");

endmodule

bind periodic_virtual_timer_bank pvtb_checker u_pvtb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_mask  (rsp.expired_mask)
);
